>>> rtl/tcr_pkg.sv
// Package for the text cell row renderer: geometry constants, register indexes,
// gray levels, the work descriptor passed from front to back, and luma helpers.
// No dependencies.
`default_nettype none

package tcr_pkg;

  localparam int CELL_W   = 8;
  localparam int CELL_H   = 16;
  localparam int MAX_COLS = 256;

  localparam int GLYPH_BITS = 16;
  localparam int GIDX_W     = $clog2(GLYPH_BITS);
  localparam int WCNT_W     = $clog2(CELL_W);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // glyph padding for half and double width glyphs
  localparam int PAD_HALF = ((CELL_W + 7) / 8) * 8 - CELL_W;
  localparam int PAD_WIDE = ((2 * CELL_W + 7) / 8) * 8 - 2 * CELL_W;

  localparam logic [1:0] WK_HALF  = 2'd0;
  localparam logic [1:0] WK_WIDE  = 2'd1;
  localparam logic [1:0] WK_RIGHT = 2'd2;

  localparam logic [2:0] REG_LANDSCAPE   = 3'd0;
  localparam logic [2:0] REG_MARGIN_LEFT = 3'd1;
  localparam logic [2:0] REG_MARGIN_TOP  = 3'd2;
  localparam logic [2:0] REG_SCREEN_H    = 3'd3;
  localparam logic [2:0] REG_CURSOR_FG   = 3'd4;
  localparam logic [2:0] REG_CURSOR_BG   = 3'd5;

  localparam logic [15:0] PIX_BLACK = 16'hFFFF;
  localparam logic [15:0] PIX_WHITE = 16'h0000;

  localparam logic [7:0] LUMA_BLACK_MAX = 8'd85;
  localparam logic [7:0] LUMA_WHITE_MIN = 8'd170;

  typedef enum logic [1:0] {
    GRAY_BLACK  = 2'd0,
    GRAY_DITHER = 2'd1,
    GRAY_WHITE  = 2'd2
  } gray_t;

  typedef struct packed {
    logic        landscape;
    logic [9:0]  margin_left;
    logic [9:0]  margin_top;
    logic [11:0] screen_height;
    logic [23:0] cursor_fg;
    logic [23:0] cursor_bg;
  } cfg_t;

  typedef struct packed {
    logic [CELL_W-1:0] set;      // glyph bit per output column
    gray_t             fg;
    gray_t             bg;
    logic              h_odd;
    logic              landscape;
    logic [11:0]       fixed;    // coordinate that stays constant along the row
    logic [11:0]       xb;       // coordinate of column 0
  } desc_t;

  function automatic logic [15:0] luma_sum(input logic [23:0] rgb);
    logic [15:0] r, g, b;
    r = {8'd0, rgb[23:16]};
    g = {8'd0, rgb[15:8]};
    b = {8'd0, rgb[7:0]};
    return 16'd54 * r + 16'd182 * g + 16'd19 * b;
  endfunction

  // exact x/255 for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

  function automatic gray_t gray_of(input logic [7:0] bright);
    if (bright <= LUMA_BLACK_MAX) return GRAY_BLACK;
    if (bright < LUMA_WHITE_MIN) return GRAY_DITHER;
    return GRAY_WHITE;
  endfunction

  function automatic int pad_of(input logic [1:0] kind);
    case (kind)
      WK_WIDE:  return PAD_WIDE + CELL_W;
      WK_RIGHT: return PAD_WIDE;
      default:  return PAD_HALF;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> rtl/tcr_front.sv
// Front end: takes a cell row, applies the cursor, picks glyph bits, then
// resolves grays and canvas coordinates into a descriptor. Uses tcr_pkg.
`default_nettype none

module tcr_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tcr_pkg::cfg_t  cfg,
  input  wire logic           start,
  output logic                busy,
  input  wire logic [23:0]    in_fg_color,
  input  wire logic [23:0]    in_bg_color,
  input  wire logic [15:0]    in_glyph_bits,
  input  wire logic [1:0]     in_width_kind,
  input  wire logic           in_underline,
  input  wire logic [3:0]     in_glyph_row,
  input  wire logic [7:0]     in_column,
  input  wire logic [6:0]     in_text_line,
  input  wire logic           in_cursor_on_line,
  input  wire logic [7:0]     in_cursor_column,
  input  wire logic           q_full,
  output logic                q_push,
  output tcr_pkg::desc_t      q_wdata
);
  import tcr_pkg::*;

  logic              accept;
  logic              in_range;
  logic              hit;
  logic [23:0]       fg_sel, bg_sel;
  logic [CELL_W-1:0] set_c;

  logic              s1_valid_r, s1_valid_nxt;
  logic [15:0]       fsum_r, bsum_r;
  logic [CELL_W-1:0] set_r;
  logic [3:0]        h_r;
  logic              ul_r;
  logic [6:0]        line_r;
  logic [7:0]        col_r;

  logic [7:0]  fb, bb;
  gray_t       fgr, bgr, fgr_adj, bgr_adj;
  logic [11:0] z, zl, xb;

  assign busy   = s1_valid_r && q_full;
  assign accept = start && !busy;
  assign q_push = s1_valid_r && !q_full;

  // stage 1: cursor override, luma sums, glyph bit selection
  always_comb begin
    int idx;
    int pad;
    in_range = (32'(in_column) < MAX_COLS);
    hit = in_cursor_on_line &&
          ((in_column == in_cursor_column) ||
           ((in_width_kind == WK_WIDE) &&
            ({1'b0, in_column} + 9'd1 == {1'b0, in_cursor_column})) ||
           ((in_width_kind == WK_RIGHT) &&
            ({1'b0, in_column} == {1'b0, in_cursor_column} + 9'd1)));
    fg_sel = hit ? cfg.cursor_fg : in_fg_color;
    bg_sel = hit ? cfg.cursor_bg : in_bg_color;
    pad = pad_of(in_width_kind);
    for (int w = 0; w < CELL_W; w++) begin
      idx = pad + CELL_W - 1 - w;
      set_c[w] = (idx < GLYPH_BITS) && in_glyph_bits[GIDX_W'(idx)];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (q_push) s1_valid_nxt = 1'b0;
    if (accept) s1_valid_nxt = in_range;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fsum_r <= luma_sum(fg_sel);
      bsum_r <= luma_sum(bg_sel);
      set_r  <= set_c;
      h_r    <= in_glyph_row;
      ul_r   <= in_underline;
      line_r <= in_text_line;
      col_r  <= in_column;
    end
  end

  // stage 2: grays, separation, underline swap, coordinates
  always_comb begin
    fb = div255(fsum_r);
    bb = div255(bsum_r);
    fgr = gray_of(fb);
    bgr = gray_of(bb);
    fgr_adj = fgr;
    bgr_adj = bgr;
    if (fgr == bgr) begin
      if (fb < bb) begin
        case (fgr)
          GRAY_DITHER: fgr_adj = GRAY_BLACK;
          GRAY_WHITE:  fgr_adj = GRAY_DITHER;
          default:     bgr_adj = GRAY_DITHER;
        endcase
      end else begin
        case (bgr)
          GRAY_DITHER: bgr_adj = GRAY_BLACK;
          GRAY_WHITE:  bgr_adj = GRAY_DITHER;
          default:     fgr_adj = GRAY_DITHER;
        endcase
      end
    end

    z  = {2'd0, cfg.margin_top} + 12'(32'(line_r) * CELL_H);
    zl = cfg.screen_height - z;
    xb = {2'd0, cfg.margin_left} + 12'(32'(col_r) * CELL_W);

    q_wdata.set       = set_r;
    q_wdata.h_odd     = h_r[0];
    q_wdata.landscape = cfg.landscape;
    q_wdata.xb        = xb;
    q_wdata.fixed     = cfg.landscape ? (zl - {8'd0, h_r}) : (z + {8'd0, h_r});
    if (ul_r && (32'(h_r) == CELL_H - 1)) begin
      q_wdata.fg = bgr_adj;
      q_wdata.bg = fgr_adj;
    end else begin
      q_wdata.fg = fgr_adj;
      q_wdata.bg = bgr_adj;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcr_queue.sv
// Short descriptor queue decoupling the front end from the pixel emitter.
// Holds tcr_pkg::desc_t entries; depth from tcr_pkg::QDEPTH.
`default_nettype none

module tcr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tcr_pkg::desc_t wdata,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output tcr_pkg::desc_t      rdata
);
  import tcr_pkg::*;

  desc_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

>>> rtl/tcr_back.sv
// Back end: walks each descriptor one column per cycle and drives the
// registered pixel outputs. Uses tcr_pkg.
`default_nettype none

module tcr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_not_empty,
  input  wire tcr_pkg::desc_t q_rdata,
  output logic                q_pop,
  output logic                out_strobe,
  output logic [11:0]         out_pos_x,
  output logic [11:0]         out_pos_y,
  output logic [15:0]         out_pixel,
  output logic                out_last
);
  import tcr_pkg::*;

  localparam logic [WCNT_W-1:0] LAST_W = WCNT_W'(CELL_W - 1);

  desc_t             cur_r, cur_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic [WCNT_W-1:0] w_r, w_nxt;
  logic              at_end;

  logic        strobe_r;
  logic [11:0] pos_x_r, pos_x_nxt;
  logic [11:0] pos_y_r, pos_y_nxt;
  logic [15:0] pixel_r, pixel_nxt;
  logic        last_r;

  gray_t       g;
  logic [11:0] run;

  assign at_end = cur_valid_r && (w_r == LAST_W);
  assign q_pop  = q_not_empty && (!cur_valid_r || at_end);

  always_comb begin
    cur_nxt       = q_pop ? q_rdata : cur_r;
    cur_valid_nxt = q_pop ? 1'b1 : (at_end ? 1'b0 : cur_valid_r);
    w_nxt         = (!cur_valid_r || at_end) ? '0 : w_r + 1'b1;

    g = cur_r.set[w_r] ? cur_r.fg : cur_r.bg;
    case (g)
      GRAY_WHITE:  pixel_nxt = PIX_WHITE;
      GRAY_BLACK:  pixel_nxt = PIX_BLACK;
      default:     pixel_nxt = (cur_r.h_odd == w_r[0]) ? PIX_WHITE : PIX_BLACK;
    endcase
    run = cur_r.xb + 12'(w_r);
    pos_x_nxt = cur_r.landscape ? cur_r.fixed : run;
    pos_y_nxt = cur_r.landscape ? run : cur_r.fixed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      w_r         <= '0;
      strobe_r    <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      w_r         <= w_nxt;
      strobe_r    <= cur_valid_r;
      last_r      <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    pos_x_r <= pos_x_nxt;
    pos_y_r <= pos_y_nxt;
    pixel_r <= pixel_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_pos_x  = pos_x_r;
  assign out_pos_y  = pos_y_r;
  assign out_pixel  = pixel_r;
  assign out_last   = last_r;

  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n) last_r |-> strobe_r)
    else $error("last flag without strobe");
  a_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
      (cur_valid_r && (w_r != LAST_W)) |=> (cur_valid_r && (w_r == $past(w_r) + 1'b1)))
    else $error("row walk broke before its last column");

endmodule

`default_nettype wire

>>> rtl/text_cell_row_renderer_core.sv
// Text cell row renderer, top level: configuration registers plus the
// front end, descriptor queue and pixel emitter. Uses tcr_pkg.
//
// One start transaction carries one glyph row of one terminal cell and yields
// CELL_W (8) pixel results on consecutive cycles, with out_last on the final
// one. The first passes through the front register, the queue, the emitter's
// current descriptor register and its output registers. The pixel emitter
// writes one column per cycle; the front end and a two-entry queue keep it fed,
// so busy rises only when the queue and the front register are both full.
// Results are strobed for one cycle and cannot be held off. A column at or
// beyond MAX_COLS produces no results. Write the cfg registers only while no
// results are pending; cfg_ready is always high.
`default_nettype none

module text_cell_row_renderer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [23:0] in_fg_color,
  input  wire logic [23:0] in_bg_color,
  input  wire logic [15:0] in_glyph_bits,
  input  wire logic [1:0]  in_width_kind,
  input  wire logic        in_underline,
  input  wire logic [3:0]  in_glyph_row,
  input  wire logic [7:0]  in_column,
  input  wire logic [6:0]  in_text_line,
  input  wire logic        in_cursor_on_line,
  input  wire logic [7:0]  in_cursor_column,
  output logic             out_strobe,
  output logic [11:0]      out_pos_x,
  output logic [11:0]      out_pos_y,
  output logic [15:0]      out_pixel,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);
  import tcr_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  q_full, q_push, q_pop, q_not_empty;
  desc_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_LANDSCAPE:   cfg_nxt.landscape     = cfg_wdata[0];
        REG_MARGIN_LEFT: cfg_nxt.margin_left   = cfg_wdata[9:0];
        REG_MARGIN_TOP:  cfg_nxt.margin_top    = cfg_wdata[9:0];
        REG_SCREEN_H:    cfg_nxt.screen_height = cfg_wdata[11:0];
        REG_CURSOR_FG:   cfg_nxt.cursor_fg     = cfg_wdata;
        REG_CURSOR_BG:   cfg_nxt.cursor_bg     = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.landscape     <= 1'b0;
      cfg_r.margin_left   <= '0;
      cfg_r.margin_top    <= '0;
      cfg_r.screen_height <= 12'd1872;
      cfg_r.cursor_fg     <= 24'h000000;
      cfg_r.cursor_bg     <= 24'hFFFFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .start             (start),
    .busy              (busy),
    .in_fg_color       (in_fg_color),
    .in_bg_color       (in_bg_color),
    .in_glyph_bits     (in_glyph_bits),
    .in_width_kind     (in_width_kind),
    .in_underline      (in_underline),
    .in_glyph_row      (in_glyph_row),
    .in_column         (in_column),
    .in_text_line      (in_text_line),
    .in_cursor_on_line (in_cursor_on_line),
    .in_cursor_column  (in_cursor_column),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_wdata           (q_wdata)
  );

  tcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  tcr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_strobe  (out_strobe),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_pixel   (out_pixel),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire

>>> tb/sv/text_cell_row_renderer_core_test.sv
// Self-checking testbench for text_cell_row_renderer_core: directed glyph rows, then random
// rows under several register settings and idle patterns, each pixel checked by a predictor or
// against typed values. Depends on tcr_pkg and the core RTL.
`default_nettype none

module text_cell_row_renderer_core_test;
  import tcr_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int ROWS_PER_PHASE = 89;
  localparam int NUM_PHASES = 5;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam logic [1:0] WK_SPARE = 2'd3;

  typedef struct packed {
    logic [23:0] fg;
    logic [23:0] bg;
    logic [15:0] bits;
    logic [1:0]  kind;
    logic        ul;
    logic [3:0]  row;
    logic [7:0]  col;
    logic [6:0]  line;
    logic        cur_on;
    logic [7:0]  cur_col;
  } glyph_row_t;

  typedef struct packed {
    glyph_row_t  item;
    logic        typed;    // expected pixels given below instead of predicted
    logic [11:0] x0;
    logic [11:0] y0;
    logic [15:0] pix;
  } dir_row_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [15:0] pix;
    logic        last;
  } pix_res_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [23:0] in_fg_color;
  logic [23:0] in_bg_color;
  logic [15:0] in_glyph_bits;
  logic [1:0]  in_width_kind;
  logic        in_underline;
  logic [3:0]  in_glyph_row;
  logic [7:0]  in_column;
  logic [6:0]  in_text_line;
  logic        in_cursor_on_line;
  logic [7:0]  in_cursor_column;
  logic        out_strobe;
  logic [11:0] out_pos_x;
  logic [11:0] out_pos_y;
  logic [15:0] out_pixel;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_wdata;

  // register shadow
  logic        sh_landscape;
  logic [9:0]  sh_margin_left;
  logic [9:0]  sh_margin_top;
  logic [11:0] sh_screen_h;
  logic [23:0] sh_cursor_fg;
  logic [23:0] sh_cursor_bg;

  pix_res_t pending_px[$];
  dir_row_t dir_tab[$];
  pix_res_t want;
  int err_count;
  int rows_sent;
  int px_checked;
  int cfg_writes;
  int cycle_cnt;

  text_cell_row_renderer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_fg_color       (in_fg_color),
    .in_bg_color       (in_bg_color),
    .in_glyph_bits     (in_glyph_bits),
    .in_width_kind     (in_width_kind),
    .in_underline      (in_underline),
    .in_glyph_row      (in_glyph_row),
    .in_column         (in_column),
    .in_text_line      (in_text_line),
    .in_cursor_on_line (in_cursor_on_line),
    .in_cursor_column  (in_cursor_column),
    .out_strobe        (out_strobe),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_pixel         (out_pixel),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int bright_of(input logic [23:0] rgb);
    int r, g, b;
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    return (54 * r + 182 * g + 19 * b) / 255;
  endfunction

  function automatic gray_t level_of(input int bright);
    if (bright <= LUMA_BLACK_MAX) return GRAY_BLACK;
    if (bright < LUMA_WHITE_MIN) return GRAY_DITHER;
    return GRAY_WHITE;
  endfunction

  // Expected pixels of one glyph row under the current register shadow.
  function automatic void render_row(input glyph_row_t c);
    logic [1:0]  kind;
    logic [23:0] fg, bg;
    logic [31:0] zz, xb, xx, yy;
    int          gw, pad, fb, bb, idx, w;
    gray_t       fgr, bgr, tmp, g;
    logic        set_bit;
    pix_res_t    r;
    kind = (c.kind == WK_SPARE) ? WK_HALF : c.kind;
    gw = (kind == WK_HALF) ? CELL_W : 2 * CELL_W;
    pad = ((gw + 7) / 8) * 8 - gw;
    if (kind == WK_WIDE) pad += CELL_W;
    fg = c.fg;
    bg = c.bg;
    // a wide cell and its right half both count as covered by the cursor
    if (c.cur_on && (c.col == c.cur_col ||
                     (kind == WK_WIDE && {1'b0, c.col} + 9'd1 == {1'b0, c.cur_col}) ||
                     (kind == WK_RIGHT && {1'b0, c.col} == {1'b0, c.cur_col} + 9'd1))) begin
      fg = sh_cursor_fg;
      bg = sh_cursor_bg;
    end
    fb = bright_of(fg);
    bb = bright_of(bg);
    fgr = level_of(fb);
    bgr = level_of(bb);
    if (fgr == bgr) begin
      if (fb < bb) begin
        if (fgr != GRAY_BLACK) fgr = gray_t'(fgr - 1);
        else bgr = gray_t'(bgr + 1);
      end else begin
        if (bgr != GRAY_BLACK) bgr = gray_t'(bgr - 1);
        else fgr = gray_t'(fgr + 1);
      end
    end
    if (c.row == CELL_H - 1 && c.ul) begin
      tmp = fgr;
      fgr = bgr;
      bgr = tmp;
    end
    zz = sh_margin_top + c.line * CELL_H;
    if (sh_landscape) zz = sh_screen_h - zz;
    xb = sh_margin_left + c.col * CELL_W;
    for (w = 0; w < CELL_W; w++) begin
      idx = pad + CELL_W - 1 - w;
      set_bit = (idx < GLYPH_BITS) && c.bits[idx];
      g = set_bit ? fgr : bgr;
      case (g)
        GRAY_WHITE: r.pix = PIX_WHITE;
        GRAY_BLACK: r.pix = PIX_BLACK;
        default:    r.pix = (c.row[0] == w[0]) ? PIX_WHITE : PIX_BLACK;
      endcase
      if (sh_landscape) begin
        xx = zz - c.row;
        yy = xb + w;
      end else begin
        xx = xb + w;
        yy = zz + c.row;
      end
      r.x = xx[11:0];
      r.y = yy[11:0];
      r.last = (w == CELL_W - 1);
      pending_px.push_back(r);
    end
  endfunction

  function automatic dir_row_t mk_row(input logic [23:0] fg, input logic [23:0] bg,
                                      input logic [15:0] bits, input logic [1:0] kind,
                                      input logic ul, input logic [3:0] row,
                                      input logic [7:0] col, input logic [6:0] line,
                                      input logic cur_on, input logic [7:0] cur_col,
                                      input logic typed, input logic [11:0] x0,
                                      input logic [11:0] y0, input logic [15:0] pix);
    dir_row_t d;
    d.item = '{fg, bg, bits, kind, ul, row, col, line, cur_on, cur_col};
    d.typed = typed;
    d.x0 = x0;
    d.y0 = y0;
    d.pix = pix;
    return d;
  endfunction

  function automatic logic [23:0] pick_color();
    logic [7:0] lvl;
    case ($urandom_range(5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: begin
        // gray levels straddling the black and white thresholds
        case ($urandom_range(3))
          0: lvl = 8'h55;
          1: lvl = 8'h56;
          2: lvl = 8'hA9;
          default: lvl = 8'hAA;
        endcase
        return {lvl, lvl, lvl};
      end
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic glyph_row_t rand_row();
    glyph_row_t c;
    c.fg = pick_color();
    c.bg = pick_color();
    c.bits = 16'($urandom);
    c.kind = 2'($urandom_range(3));
    c.ul = 1'($urandom_range(1));
    c.row = ($urandom_range(3) == 0) ? 4'd15 : 4'($urandom_range(15));
    c.col = 8'($urandom_range(255));
    c.line = 7'($urandom_range(127));
    c.cur_on = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: c.cur_col = c.col;
      1: c.cur_col = c.col + 8'd1;
      2: c.cur_col = c.col - 8'd1;
      default: c.cur_col = 8'($urandom_range(255));
    endcase
    return c;
  endfunction

  task automatic put_fields(input glyph_row_t c);
    in_fg_color = c.fg;
    in_bg_color = c.bg;
    in_glyph_bits = c.bits;
    in_width_kind = c.kind;
    in_underline = c.ul;
    in_glyph_row = c.row;
    in_column = c.col;
    in_text_line = c.line;
    in_cursor_on_line = c.cur_on;
    in_cursor_column = c.cur_col;
  endtask

  task automatic send_row(input dir_row_t d);
    int w;
    pix_res_t r;
    @(negedge clk);
    start = 1'b1;
    put_fields(d.item);
    do @(posedge clk); while (busy);
    rows_sent++;
    if (d.typed) begin
      for (w = 0; w < CELL_W; w++) begin
        r.x = d.x0 + 12'(w);
        r.y = d.y0;
        r.pix = d.pix;
        r.last = (w == CELL_W - 1);
        pending_px.push_back(r);
      end
    end else begin
      render_row(d.item);
    end
  endtask

  // Junk on the fields while start is low must be ignored.
  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start = 1'b0;
      put_fields(rand_row());
    end
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [23:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      REG_LANDSCAPE:   sh_landscape = data[0];
      REG_MARGIN_LEFT: sh_margin_left = data[9:0];
      REG_MARGIN_TOP:  sh_margin_top = data[9:0];
      REG_SCREEN_H:    sh_screen_h = data[11:0];
      REG_CURSOR_FG:   sh_cursor_fg = data;
      REG_CURSOR_BG:   sh_cursor_bg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(input logic [23:0] lsc, input logic [23:0] ml,
                           input logic [23:0] mt, input logic [23:0] sh,
                           input logic [23:0] cf, input logic [23:0] cb);
    cfg_write(REG_LANDSCAPE, lsc);
    cfg_write(REG_MARGIN_LEFT, ml);
    cfg_write(REG_MARGIN_TOP, mt);
    cfg_write(REG_SCREEN_H, sh);
    cfg_write(REG_CURSOR_FG, cf);
    cfg_write(REG_CURSOR_BG, cb);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_px.size() == 0) begin
        $error("unexpected pixel at x %0d y %0d", out_pos_x, out_pos_y);
        err_count++;
      end else begin
        want = pending_px.pop_front();
        px_checked++;
        if (out_pos_x !== want.x) begin
          $error("pos_x: expected %0d, got %0d", want.x, out_pos_x);
          err_count++;
        end
        if (out_pos_y !== want.y) begin
          $error("pos_y: expected %0d, got %0d", want.y, out_pos_y);
          err_count++;
        end
        if (out_pixel !== want.pix) begin
          $error("pixel: expected %h, got %h", want.pix, out_pixel);
          err_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("text_cell_row_renderer_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    int ph, i, pct;
    dir_row_t rd;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_LANDSCAPE;
    cfg_wdata = '0;
    put_fields('0);
    err_count = 0;
    rows_sent = 0;
    px_checked = 0;
    cfg_writes = 0;
    cycle_cnt = 0;
    sh_landscape = 1'b0;
    sh_margin_left = '0;
    sh_margin_top = '0;
    sh_screen_h = 12'd1872;
    sh_cursor_fg = 24'h000000;
    sh_cursor_bg = 24'hFFFFFF;

    // directed rows, all under reset register values
    //                     fg          bg          bits     kind      ul row col line cur
    dir_tab.push_back(mk_row(24'h000000, 24'hFFFFFF, 16'h00FF, WK_HALF, 0, 0, 0, 0, 0, 0,
                             1, 0, 0, PIX_BLACK));
    dir_tab.push_back(mk_row(24'h000000, 24'hFFFFFF, 16'hFF00, WK_HALF, 0, 0, 0, 0, 0, 0,
                             1, 0, 0, PIX_WHITE));
    dir_tab.push_back(mk_row(24'hFFFFFF, 24'h000000, 16'hFFFF, WK_HALF, 0, 15, 255, 127, 0, 0,
                             1, 2040, 2047, PIX_WHITE));
    // underline on the bottom row swaps the grays
    dir_tab.push_back(mk_row(24'hFFFFFF, 24'h000000, 16'hFFFF, WK_HALF, 1, 15, 255, 127, 0, 0,
                             1, 2040, 2047, PIX_BLACK));
    // cursor colors replace the cell colors
    dir_tab.push_back(mk_row(24'hFFFFFF, 24'h000000, 16'hFFFF, WK_HALF, 0, 0, 5, 0, 1, 5,
                             1, 40, 0, PIX_BLACK));
    dir_tab.push_back(mk_row(24'hFFFFFF, 24'h000000, 16'hFFFF, WK_HALF, 0, 0, 5, 0, 0, 5,
                             1, 40, 0, PIX_WHITE));
    dir_tab.push_back(mk_row(24'hFFFFFF, 24'h000000, 16'hA5C3, WK_WIDE, 0, 3, 10, 2, 1, 11,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(24'hFFFFFF, 24'h000000, 16'h5AC3, WK_RIGHT, 0, 4, 11, 2, 1, 10,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(24'hFFFFFF, 24'h000000, 16'hA5C3, WK_WIDE, 0, 3, 11, 2, 1, 10,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(24'hFFFFFF, 24'h000000, 16'h5AC3, WK_RIGHT, 0, 4, 10, 2, 1, 11,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(24'h00FF00, 24'h0000FF, 16'h0F0F, WK_SPARE, 0, 1, 3, 9, 0, 3,
                             0, 0, 0, 0));
    // equal grays: black, white, dither both ways
    dir_tab.push_back(mk_row(24'h000000, 24'h000000, 16'h5555, WK_HALF, 0, 2, 1, 1, 0, 0,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(24'hFFFFFF, 24'hFFFFFF, 16'hAAAA, WK_HALF, 0, 5, 2, 1, 0, 0,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(24'h565656, 24'hA9A9A9, 16'h3333, WK_HALF, 0, 6, 3, 1, 0, 0,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(24'hA9A9A9, 24'h565656, 16'hCCCC, WK_HALF, 0, 7, 4, 1, 0, 0,
                             0, 0, 0, 0));
    // underline above the bottom row has no effect; on the bottom row it swaps the grays
    dir_tab.push_back(mk_row(24'hAAAAAA, 24'h555555, 16'h3C3C, WK_HALF, 1, 14, 6, 3, 0, 0,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(24'h808080, 24'h000000, 16'hF00F, WK_HALF, 1, 15, 7, 3, 0, 0,
                             0, 0, 0, 0));
    // cursor index arithmetic must not wrap at the line end
    dir_tab.push_back(mk_row(24'hFFFFFF, 24'h000000, 16'h8181, WK_RIGHT, 0, 8, 0, 4, 1, 255,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(24'hFFFFFF, 24'h000000, 16'h8181, WK_WIDE, 0, 8, 255, 4, 1, 0,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(24'hFFFFFF, 24'h000000, 16'hFFFF, WK_RIGHT, 0, 9, 1, 5, 1, 0,
                             0, 0, 0, 0));
    dir_tab.push_back(mk_row(24'h123456, 24'hFEDCBA, 16'h6789, WK_WIDE, 0, 15, 128, 64, 0, 77,
                             0, 0, 0, 0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[k]) send_row(dir_tab[k]);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      @(negedge clk);
      start = 1'b0;
      while (pending_px.size() != 0) @(posedge clk);
      repeat (12) @(posedge clk);
      case (ph)
        0: begin
          // unmapped indexes must leave every register alone
          cfg_write(REG_SPARE_LO, 24'($urandom));
          cfg_write(REG_SPARE_HI, 24'($urandom));
          write_all(1, 1023, 1023, 4095, 24'hFFFFFF, 24'h000000);
          pct = 0;
        end
        1: begin
          write_all(1, 0, 0, 0, 24'($urandom), 24'($urandom));
          pct = 53;
        end
        2: begin
          write_all(0, 24'($urandom), 24'($urandom), 24'($urandom), 24'h808080, 24'h555555);
          pct = 20;
        end
        3: begin
          write_all(24'($urandom_range(1)), 24'($urandom), 24'($urandom), 24'($urandom),
                    24'($urandom), 24'($urandom));
          pct = 53;
        end
        default: begin
          write_all(0, 1023, 0, 1872, 24'h000000, 24'hFFFFFF);
          pct = 0;
        end
      endcase
      for (i = 0; i < ROWS_PER_PHASE; i++) begin
        if (ph == NUM_PHASES - 1) begin
          case ((i / 16) % 3)
            0: pct = 0;
            1: pct = 53;
            default: pct = 20;
          endcase
        end
        idle_gap(pct);
        rd = '0;
        rd.item = rand_row();
        send_row(rd);
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("%0d glyph rows sent, %0d pixels checked, %0d register writes",
             rows_sent, px_checked, cfg_writes);
    $display("register phases: reset, landscape extremes, mirror wrap, random, portrait");
    if (err_count == 0) begin
      $display("text_cell_row_renderer_core_test: done, clean");
    end else begin
      $display("text_cell_row_renderer_core_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/tcr_pkg.sv
rtl/tcr_front.sv
rtl/tcr_queue.sv
rtl/tcr_back.sv
rtl/text_cell_row_renderer_core.sv
tb/sv/text_cell_row_renderer_core_test.sv
